// File: design/ftcd_pkg.sv
`default_nettype none
package ftcd_pkg;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 256;
    localparam int OUT_W    = 40;
    localparam int ENTRY_W  = 48;
    localparam int NENTRY   = 36;

    localparam logic [3:0] OP_STRAIN_A  = 4'd0;
    localparam logic [3:0] OP_STRAIN_B  = 4'd1;
    localparam logic [3:0] OP_MATRIX_0  = 4'd2;
    localparam logic [3:0] OP_MATRIX_1  = 4'd3;
    localparam logic [3:0] OP_MATRIX_2  = 4'd4;
    localparam logic [3:0] OP_COUNTS    = 4'd7;
    localparam logic [3:0] OP_UNITS     = 4'd8;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: design/force_torque_can_decoder_top.sv
// Six-axis force/torque sensor CAN decoder.
// The s_ channel takes one CAN frame per item; frames whose id bits 10..4
// differ from the base id register are dropped. Frames carry strain words,
// counts per unit, unit codes and the 6x6 calibration matrix as floats.
// The m_ channel gives one item for each accepted opcode 1 frame: the
// calibrated force and torque vector and the last reported unit codes.
// Strain A, counts, unit and axis-select frames leave the block ready again in the next cycle.
// A matrix frame converts two floats one after the other by a bit-serial
// restoring divider: per float a start state, 24 + max(0, exponent - 118)
// division steps and a final write; fewer steps when the value saturates.
// An opcode 1 frame walks the 36 matrix entries through the single read
// port of the matrix memory and one 48x16 multiplier, then waits for the
// output register if it is still held.
// The block accepts one frame at a time; s_tready is high whenever it is
// idle, also while a finished item waits in the output register.
// Reset clears control, strain, count, unit and axis registers, sets base
// id 127 and marks all matrix entries zero; no clearing pass is needed.
// When the receiver stalls, the item is held and a further opcode 1 frame
// waits in its final cycle until the output register is free.
`default_nettype none
module force_torque_can_decoder_top
    import ftcd_pkg::*;
(
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    // can_id[10:0], payload_len[14:11], payload[78:15], zero [79]
    input  wire  [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  wire                 m_tready,
    // force_x, force_y, force_z, torque_x, torque_y, torque_z (40 bits each),
    // force_unit_code[247:240], torque_unit_code[255:248]
    output logic [M_DATA_W-1:0] m_tdata,
    input  wire                 cfg_wen,
    input  wire  [6:0]          cfg_wdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DSTART = 3'd1;
    localparam logic [2:0] ST_DRUN   = 3'd2;
    localparam logic [2:0] ST_DFIN   = 3'd3;
    localparam logic [2:0] ST_MAC    = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;

    logic [2:0]  state_reg;
    logic [6:0]  base_id_reg;
    logic signed [15:0] sw_reg [0:5];
    logic [7:0]  axis_reg;
    logic [31:0] cnt_f_reg, cnt_t_reg;
    logic [7:0]  unit_f_reg, unit_t_reg;
    logic [NENTRY-1:0] valid_reg;
    logic [ENTRY_W-1:0] calib_mem [0:NENTRY-1];

    logic [63:0] pl_reg;
    logic [5:0]  addr_reg;
    logic        sel_reg;
    logic [31:0] c_reg;
    logic        neg_reg;
    logic [23:0] m_reg;
    logic [6:0]  shr_reg;
    logic [7:0]  steps_reg;
    logic [31:0] r_reg;
    logic [ENTRY_W-1:0] q_reg;

    logic        iss_on_reg;
    logic [5:0]  iss_cnt_reg;
    logic [2:0]  iss_col_reg, iss_row_reg;
    logic        p1_v_reg;
    logic [2:0]  p1_col_reg, p1_row_reg;
    logic [ENTRY_W-1:0] mem_q_reg;
    logic        vld_q_reg;
    logic        p2_v_reg;
    logic [2:0]  p2_col_reg, p2_row_reg;
    logic signed [63:0] prod_reg;
    logic signed [66:0] acc_reg;
    logic signed [OUT_W-1:0] res_reg [0:5];

    logic              out_v_reg;
    logic [M_DATA_W-1:0] out_reg;

    logic [10:0] in_id;
    logic [3:0]  in_len, in_op;
    logic [63:0] in_pl;
    logic        accept, hit;

    assign in_id  = s_tdata[10:0];
    assign in_len = s_tdata[14:11];
    assign in_pl  = s_tdata[78:15];
    assign in_op  = in_id[3:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign hit    = accept && (in_id[10:4] == base_id_reg);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;

    logic [31:0] f_cur;
    logic [7:0]  f_ex, ex_eff;
    logic signed [8:0] s_exp;
    logic [32:0] r_shift;
    logic        q_bit;
    logic [ENTRY_W-1:0] q_new, q_shr, entry_val;
    logic [31:0] c_sel;
    logic signed [66:0] sum;
    logic signed [66:0] sum_sh;
    logic signed [OUT_W-1:0] sat_val;
    logic [5:0] axis_base;

    always_comb begin
        f_cur   = sel_reg ? pl_reg[31:0] : pl_reg[63:32];
        f_ex    = f_cur[30:23];
        ex_eff  = (f_ex == 8'd0) ? 8'd1 : f_ex;
        s_exp   = $signed({1'b0, ex_eff}) - 9'sd118;
        r_shift = {r_reg, m_reg[23]};
        q_bit   = (r_shift >= {1'b0, c_reg});
        q_new   = {q_reg[ENTRY_W-2:0], q_bit};
        q_shr   = (shr_reg >= 7'd48) ? '0 : (q_reg >> shr_reg);
        entry_val = neg_reg ? (ENTRY_W'(0) - q_shr) : q_shr;
        c_sel   = (axis_reg < 8'd3) ? cnt_f_reg : cnt_t_reg;
        axis_base = {axis_reg[2:0], 2'b00} + {1'b0, axis_reg[2:0], 1'b0};
        sum     = ((p2_col_reg == 3'd0) ? 67'sd0 : acc_reg) + 67'(prod_reg);
        sum_sh  = sum >>> 16;
        if (sum_sh > 67'(OUT_MAX)) begin
            sat_val = OUT_MAX;
        end else if (sum_sh < 67'(OUT_MIN)) begin
            sat_val = OUT_MIN;
        end else begin
            sat_val = sum_sh[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DFIN) begin
            calib_mem[addr_reg] <= entry_val;
        end
        mem_q_reg <= calib_mem[iss_cnt_reg];
        vld_q_reg <= valid_reg[iss_cnt_reg];
        prod_reg  <= $signed(vld_q_reg ? mem_q_reg : ENTRY_W'(0)) * sw_reg[p1_col_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            base_id_reg <= 7'h7F;
            for (int i = 0; i < 6; i++) begin
                sw_reg[i] <= '0;
            end
            axis_reg    <= '0;
            cnt_f_reg   <= '0;
            cnt_t_reg   <= '0;
            unit_f_reg  <= '0;
            unit_t_reg  <= '0;
            valid_reg   <= '0;
            iss_on_reg  <= 1'b0;
            p1_v_reg    <= 1'b0;
            p2_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            if (cfg_wen) begin
                base_id_reg <= cfg_wdata;
            end
            if (out_v_reg && m_tready && state_reg != ST_EMIT) begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (hit) begin
                        case (in_op)
                            OP_STRAIN_A: begin
                                if (in_len != 4'd0) begin
                                    sw_reg[0] <= $signed(in_pl[47:32]);
                                    sw_reg[2] <= $signed(in_pl[31:16]);
                                    sw_reg[4] <= $signed(in_pl[15:0]);
                                end
                            end
                            OP_STRAIN_B: begin
                                sw_reg[1]   <= $signed(in_pl[63:48]);
                                sw_reg[3]   <= $signed(in_pl[47:32]);
                                sw_reg[5]   <= $signed(in_pl[31:16]);
                                iss_on_reg  <= 1'b1;
                                iss_cnt_reg <= '0;
                                iss_col_reg <= '0;
                                iss_row_reg <= '0;
                                state_reg   <= ST_MAC;
                            end
                            OP_MATRIX_0, OP_MATRIX_1, OP_MATRIX_2: begin
                                if (in_len == 4'd1) begin
                                    axis_reg <= in_pl[63:56];
                                end else if (axis_reg <= 8'd5 && c_sel != 32'd0) begin
                                    pl_reg    <= in_pl;
                                    c_reg     <= c_sel;
                                    sel_reg   <= 1'b0;
                                    addr_reg  <= axis_base + {1'b0, in_op - OP_MATRIX_0, 1'b0};
                                    state_reg <= ST_DSTART;
                                end
                            end
                            OP_COUNTS: begin
                                if (in_len != 4'd0) begin
                                    cnt_f_reg <= in_pl[63:32];
                                    cnt_t_reg <= in_pl[31:0];
                                end
                            end
                            OP_UNITS: begin
                                if (in_len != 4'd0) begin
                                    unit_f_reg <= in_pl[63:56];
                                    unit_t_reg <= in_pl[55:48];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DSTART: begin
                    neg_reg <= f_cur[31];
                    m_reg   <= (f_ex == 8'd0) ? {1'b0, f_cur[22:0]} : {1'b1, f_cur[22:0]};
                    r_reg   <= '0;
                    if (f_ex == 8'hFF) begin
                        q_reg     <= (f_cur[22:0] != 23'd0) ? '0 : ENTRY_MAX;
                        shr_reg   <= '0;
                        state_reg <= ST_DFIN;
                    end else begin
                        q_reg <= '0;
                        if (s_exp < 0) begin
                            shr_reg   <= 7'(-s_exp);
                            steps_reg <= 8'd24;
                        end else begin
                            shr_reg   <= '0;
                            steps_reg <= 8'd24 + 8'(s_exp);
                        end
                        state_reg <= ST_DRUN;
                    end
                end
                ST_DRUN: begin
                    m_reg     <= {m_reg[22:0], 1'b0};
                    r_reg     <= q_bit ? 32'(r_shift - {1'b0, c_reg}) : r_shift[31:0];
                    steps_reg <= steps_reg - 8'd1;
                    if (q_new[ENTRY_W-1]) begin
                        q_reg     <= ENTRY_MAX;
                        state_reg <= ST_DFIN;
                    end else begin
                        q_reg <= q_new;
                        if (steps_reg == 8'd1) begin
                            state_reg <= ST_DFIN;
                        end
                    end
                end
                ST_DFIN: begin
                    valid_reg[addr_reg] <= 1'b1;
                    if (!sel_reg) begin
                        sel_reg   <= 1'b1;
                        addr_reg  <= addr_reg + 6'd1;
                        state_reg <= ST_DSTART;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MAC: begin
                    p1_v_reg   <= iss_on_reg;
                    p1_col_reg <= iss_col_reg;
                    p1_row_reg <= iss_row_reg;
                    p2_v_reg   <= p1_v_reg;
                    p2_col_reg <= p1_col_reg;
                    p2_row_reg <= p1_row_reg;
                    if (iss_on_reg) begin
                        iss_cnt_reg <= iss_cnt_reg + 6'd1;
                        if (iss_col_reg == 3'd5) begin
                            iss_col_reg <= '0;
                            iss_row_reg <= iss_row_reg + 3'd1;
                        end else begin
                            iss_col_reg <= iss_col_reg + 3'd1;
                        end
                        if (iss_cnt_reg == 6'(NENTRY - 1)) begin
                            iss_on_reg <= 1'b0;
                        end
                    end
                    if (p2_v_reg) begin
                        acc_reg <= sum;
                        if (p2_col_reg == 3'd5) begin
                            res_reg[p2_row_reg] <= sat_val;
                            if (p2_row_reg == 3'd5) begin
                                state_reg <= ST_EMIT;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (!out_v_reg || m_tready) begin
                        out_reg   <= {unit_t_reg, unit_f_reg, res_reg[5], res_reg[4],
                                      res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                        out_v_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: design/ftcd_checker.sv
`default_nettype none
module ftcd_checker
    import ftcd_pkg::*;
(
    input wire                aclk,
    input wire                aresetn,
    input wire                s_tvalid,
    input wire                s_tready,
    input wire [S_DATA_W-1:0] s_tdata,
    input wire                m_tvalid,
    input wire                m_tready,
    input wire [M_DATA_W-1:0] m_tdata
);

    // After reset no item is offered on the result side.
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result item offered right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // Accepted frames other than strain B and matrix frames leave the block ready in the next cycle.
    a_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[3:0] != OP_STRAIN_B
        && s_tdata[3:0] != OP_MATRIX_0 && s_tdata[3:0] != OP_MATRIX_1
        && s_tdata[3:0] != OP_MATRIX_2 |=> s_tready)
        else $error("simple frame left the block busy");

    // A new result comes only out of a busy period.
    a_rise_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result item appeared while idle");

endmodule

bind force_torque_can_decoder_top ftcd_checker u_ftcd_checker (.*);
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
module tb;
    import ftcd_pkg::*;

    localparam logic [3:0] OP_SPARE_LO = 4'd5;
    localparam logic [3:0] OP_SPARE_HI = 4'd15;
    localparam int         DRAIN_CYCLES = 400;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_wen = 1'b0;
    logic [6:0]          cfg_wdata = '0;

    force_torque_can_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Local copy of the decoder state.
    logic [6:0]                sensor_id = 7'd127;
    logic signed [15:0]        strain [6];
    logic signed [ENTRY_W-1:0] calib [NENTRY];
    logic [7:0]                axis_sel;
    logic [31:0]               cnt_force, cnt_torque;
    logic [7:0]                unit_f, unit_t;

    logic [M_DATA_W-1:0] expected_readings [$];
    int errors = 0;
    int frames_sent = 0;
    int readings_seen = 0;
    int hold = 0;
    bit quiet = 1'b0;

    function automatic logic signed [ENTRY_W-1:0] entry_from_float(logic [31:0] f,
                                                                  logic [31:0] c);
        int ex, s, k;
        logic [63:0] m, q, r;
        q = 0;
        r = 0;
        ex = int'(f[30:23]);
        if (ex == 255) begin
            if (f[22:0] != 0) return '0;
            q = 64'(ENTRY_MAX);
        end else begin
            m = (ex == 0) ? 64'(f[22:0]) : 64'({1'b1, f[22:0]});
            s = (ex == 0) ? -117 : ex - 118;
            if (s >= 0) begin
                for (int i = 0; i < 24 + s; i++) begin
                    r = (r << 1) | ((i < 24) ? 64'(m[23-i]) : 64'd0);
                    q = q << 1;
                    if (r >= 64'(c)) begin
                        r = r - 64'(c);
                        q[0] = 1'b1;
                    end
                    if (q > 64'(ENTRY_MAX)) begin
                        q = 64'(ENTRY_MAX);
                        break;
                    end
                end
            end else begin
                k = -s;
                q = m / 64'(c);
                q = (k >= 64) ? 64'd0 : (q >> k);
                if (q > 64'(ENTRY_MAX)) q = 64'(ENTRY_MAX);
            end
        end
        return f[31] ? -q[ENTRY_W-1:0] : q[ENTRY_W-1:0];
    endfunction

    function automatic logic [15:0] word_at(logic [63:0] p, int k);
        return p[63-8*k -: 16];
    endfunction

    task automatic decode_frame(logic [10:0] id, logic [3:0] len, logic [63:0] p);
        logic [3:0]          op;
        logic [31:0]         c;
        int                  b;
        logic signed [71:0]  sum, acc;
        logic [M_DATA_W-1:0] res;
        op = id[3:0];
        if (id[10:4] != sensor_id) return;
        case (op)
            OP_STRAIN_A: begin
                if (len != 0) begin
                    strain[0] = word_at(p, 2);
                    strain[2] = word_at(p, 4);
                    strain[4] = word_at(p, 6);
                end
            end
            OP_STRAIN_B: begin
                strain[1] = word_at(p, 0);
                strain[3] = word_at(p, 2);
                strain[5] = word_at(p, 4);
                res = '0;
                for (int row = 0; row < 6; row++) begin
                    sum = 0;
                    for (int col = 0; col < 6; col++)
                        sum += 72'(calib[row*6+col] * 64'(strain[col]));
                    acc = sum >>> 16;
                    if (acc > 72'(OUT_MAX)) acc = 72'(OUT_MAX);
                    if (acc < 72'(OUT_MIN)) acc = 72'(OUT_MIN);
                    res[row*OUT_W +: OUT_W] = acc[OUT_W-1:0];
                end
                res[247:240] = unit_f;
                res[255:248] = unit_t;
                expected_readings.push_back(res);
            end
            OP_MATRIX_0, OP_MATRIX_1, OP_MATRIX_2: begin
                if (len == 1) begin
                    axis_sel = p[63:56];
                end else if (axis_sel <= 5) begin
                    c = (axis_sel < 3) ? cnt_force : cnt_torque;
                    if (c != 0) begin
                        b = int'(axis_sel) * 6 + int'(op - OP_MATRIX_0) * 2;
                        calib[b]   = entry_from_float(p[63:32], c);
                        calib[b+1] = entry_from_float(p[31:0], c);
                    end
                end
            end
            OP_COUNTS: begin
                if (len != 0) begin
                    cnt_force  = p[63:32];
                    cnt_torque = p[31:0];
                end
            end
            OP_UNITS: begin
                if (len != 0) begin
                    unit_f = p[63:56];
                    unit_t = p[55:48];
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_frame(logic [10:0] id, logic [3:0] len, logic [63:0] p);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, p, len, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        decode_frame(id, len, p);
        frames_sent++;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic frame(logic [3:0] op, logic [3:0] len, logic [63:0] p);
        send_frame({sensor_id, op}, len, p);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_base_id(logic [6:0] v);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sensor_id = v;
    endtask

    always @(posedge aclk) begin : result_check
        int h;
        logic [M_DATA_W-1:0] exp_v;
        if (m_tvalid && m_tready) begin
            readings_seen++;
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                errors++;
            end else begin
                exp_v = expected_readings.pop_front();
                for (int i = 0; i < 6; i++)
                    if (m_tdata[i*OUT_W +: OUT_W] !== exp_v[i*OUT_W +: OUT_W]) begin
                        $display("%0t: axis %0d expected %h actual %h", $time, i,
                                 exp_v[i*OUT_W +: OUT_W], m_tdata[i*OUT_W +: OUT_W]);
                        errors++;
                    end
                for (int i = 0; i < 2; i++)
                    if (m_tdata[240+8*i +: 8] !== exp_v[240+8*i +: 8]) begin
                        $display("%0t: unit code %0d expected %h actual %h", $time, i,
                                 exp_v[240+8*i +: 8], m_tdata[240+8*i +: 8]);
                        errors++;
                    end
            end
            h = quiet ? 0 : $urandom_range(0, 4);
            hold = h;
            m_tready <= (h == 0);
        end else if (hold != 0) begin
            hold = hold - 1;
            m_tready <= (hold == 0);
        end else begin
            m_tready <= aresetn;
        end
    end

    function automatic logic [31:0] rand_float();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
            2: return {1'($urandom), 8'($urandom_range(140, 254)), 23'($urandom)};
            3: return {1'($urandom), 8'($urandom_range(0, 1) ? 8'hFF : 8'h00),
                       23'($urandom_range(0, 1) ? $urandom : 0)};
            default: return {1'($urandom), 8'($urandom_range(118, 140)), 23'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return 1;
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    function automatic logic [3:0] rand_len();
        return $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'd8;
    endfunction

    task automatic calibrate_axis(logic [7:0] ax);
        frame(OP_MATRIX_0, 4'd1, {ax, 56'($urandom) << 8 | 56'($urandom)});
        for (int k = 0; k < 3; k++)
            frame(OP_MATRIX_0 + 4'(k), rand_len() == 4'd1 ? 4'd8 : rand_len(),
                  {rand_float(), rand_float()});
    endtask

    task automatic read_strain();
        frame(OP_STRAIN_A, rand_len() == 0 ? 4'd8 : rand_len(), {$urandom, $urandom});
        frame(OP_STRAIN_B, rand_len(), {$urandom, $urandom});
    endtask

    task automatic test_directed();
        frame(OP_UNITS, 4'd2, {8'hFF, 8'h00, 48'h0});
        frame(OP_COUNTS, 4'd8, {32'd1, 32'd0});
        frame(OP_MATRIX_0, 4'd1, {8'd0, 56'h0});
        frame(OP_MATRIX_0, 4'd8, {32'h7F80_0000, 32'h7FC0_0001});
        frame(OP_MATRIX_1, 4'd8, {32'h0000_0001, 32'h7F7F_FFFF});
        frame(OP_MATRIX_2, 4'd0, {32'hBF80_0000, 32'h8000_0000});
        frame(OP_MATRIX_0, 4'd1, {8'd3, 56'h0});
        frame(OP_MATRIX_0, 4'd8, {32'h3F80_0000, 32'h3F80_0000});
        frame(OP_MATRIX_0, 4'd1, {8'd200, 56'h0});
        frame(OP_MATRIX_1, 4'd15, {32'h3F80_0000, 32'h3F80_0000});
        frame(OP_STRAIN_A, 4'd0, {64'hFFFF_FFFF_FFFF_FFFF});
        frame(OP_STRAIN_A, 4'd3, {16'h0, 16'h7FFF, 16'h8000, 16'hFFFF});
        frame(OP_STRAIN_B, 4'd0, {16'h8000, 16'h7FFF, 16'h0001, 16'h0});
        frame(OP_SPARE_LO, 4'd8, {$urandom, $urandom});
        frame(OP_SPARE_HI, 4'd8, {$urandom, $urandom});
        send_frame({~sensor_id, OP_STRAIN_B}, 4'd8, 64'h0);
        frame(OP_COUNTS, 4'd1, {32'hFFFF_FFFF, 32'hFFFF_FFFF});
        frame(OP_MATRIX_0, 4'd1, {8'd5, 56'h0});
        frame(OP_MATRIX_2, 4'd8, {32'h7F7F_FFFF, 32'hFF80_0000});
        frame(OP_STRAIN_B, 4'd8, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h0});
        frame(OP_UNITS, 4'd1, {8'h06, 8'h06, 48'hFFFF_FFFF_FFFF});
    endtask

    task automatic test_random(int n_items);
        logic [3:0] op;
        while (frames_sent < n_items) begin
            if ($urandom_range(0, 49) == 0) quiet = ~quiet;
            case ($urandom_range(0, 9))
                0: frame(OP_COUNTS, rand_len() == 0 ? 4'd8 : rand_len(),
                         {rand_count(), rand_count()});
                1: frame(OP_UNITS, rand_len(), {$urandom, $urandom});
                2, 3, 4: calibrate_axis($urandom_range(0, 7) == 0 ? 8'($urandom)
                                                                  : 8'($urandom_range(0, 5)));
                5, 6, 7: read_strain();
                8: send_frame(11'($urandom), 4'($urandom), {$urandom, $urandom});
                default: begin
                    op = 4'($urandom);
                    frame(op, 4'($urandom), {$urandom, $urandom});
                end
            endcase
        end
        quiet = 1'b0;
    endtask

    task automatic test_base_ids();
        logic [6:0] ids [4];
        ids = '{7'd0, 7'($urandom), 7'd85, 7'd127};
        foreach (ids[i]) begin
            write_base_id(ids[i]);
            frame(OP_COUNTS, 4'd8, {rand_count(), rand_count()});
            calibrate_axis($urandom_range(0, 5));
            send_frame({ids[i] ^ 7'd1, OP_STRAIN_B}, 4'd8, {$urandom, $urandom});
            read_strain();
        end
    endtask

    task automatic test_pause();
        read_strain();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
        read_strain();
    endtask

    initial begin
        foreach (strain[i]) strain[i] = '0;
        foreach (calib[i]) calib[i] = '0;
        axis_sel = '0;
        cnt_force = '0;
        cnt_torque = '0;
        unit_f = '0;
        unit_t = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_base_ids();
        test_pause();
        write_base_id(7'($urandom));
        test_random(frames_sent + 650);
        write_base_id(7'd127);
        test_random(frames_sent + 650);
        wait_idle();
        $display("Sent %0d frames and checked %0d force/torque results.",
                 frames_sent, readings_seen);
        $display("Covered special floats, zero counts, bad axes and base id changes.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: force_torque_can_decoder_top.f
design/ftcd_pkg.sv
design/force_torque_can_decoder_top.sv
design/ftcd_checker.sv
verif/tb.sv
